[hw/rtl/shash_pkg.sv]
// ----------------------------------------------------------------------------
// shash_pkg
// Types, constants and round functions of the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package shash_pkg;

  typedef logic [31:0] word_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_ROUND,
    ST_UPDATE,
    ST_OUT
  } state_t;

  // Kind of block fed to the compression
  //   BLK_FULL    : 64 message bytes from the buffer
  //   BLK_PAD     : pending bytes, pad mark, zero fill, no length (spill block)
  //   BLK_PAD_LEN : pending bytes, pad mark, zero fill, bit length
  //   BLK_LEN     : zero fill and bit length only
  typedef enum logic [1:0] {
    BLK_FULL,
    BLK_PAD,
    BLK_PAD_LEN,
    BLK_LEN
  } blk_kind_t;

  // Input commands
  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  localparam logic [7:0] PAD_MARK       = 8'h80;
  localparam logic [6:0] BLOCK_BYTES    = 7'd64;
  localparam logic [5:0] LEN_FIELD_BYTE = 6'd56;
  localparam logic [5:0] LAST_BYTE      = 6'd63;
  localparam logic [5:0] LAST_ROUND     = 6'd63;
  localparam logic [3:0] LEN_HI_WORD    = 4'd14;
  localparam logic [3:0] LEN_LO_WORD    = 4'd15;
  localparam logic [2:0] LAST_DIGEST    = 3'd7;

  localparam word_t INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t big_sigma0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  function automatic word_t choose(input word_t e, input word_t f, input word_t g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic word_t majority(input word_t a, input word_t b, input word_t c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

[hw/rtl/shash_ifs.sv]
// ----------------------------------------------------------------------------
// shash_ifs
// Valid/ready channels of the SHA-256 stream hasher: command in, digest out.
// ----------------------------------------------------------------------------

// Command channel: one message byte or a finish request per item
interface shash_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] data_byte;

  modport source (output valid, output command, output data_byte, input ready);
  modport sink   (input valid, input command, input data_byte, output ready);
endinterface

// Digest channel: one 32-bit digest word per item
interface shash_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index,
                  output last_word, input ready);
  modport sink   (input valid, input digest_word, input word_index,
                  input last_word, output ready);
endinterface

[hw/rtl/sha256_stream_hasher.sv]
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// Streaming SHA-256: byte-wise message intake, block compression, digest out.
// ----------------------------------------------------------------------------
// An append item is stored in a 16 x 32-bit block buffer memory. The byte
// that completes a 64-byte block starts a compression: a prime step for the
// buffer read, 64 rounds on a single round unit at one round per cycle, and
// a fold of the result into the hash words, during which intake pauses. A
// finish item pads the message on the buffer's read path and compresses one
// block, or two when more than 55 bytes are pending, followed by the eight
// digest words, one per cycle while the sink is ready. After the last word
// the block is back in its initial state for the next message. No input is
// accepted during a compression or while digest words are pending.
// ----------------------------------------------------------------------------
module sha256_stream_hasher (
  input  logic               clk,
  input  logic               rst_n,
  shash_in_if.sink           in_ch,
  shash_out_if.source        out_ch
);

  shash_pkg::state_t    state_r, state_nxt;
  shash_pkg::blk_kind_t kind_r, kind_nxt;

  logic [5:0]             rnd_r;
  logic [2:0]             idx_r;
  logic [5:0]             fill_r;
  logic [60:0]            len_r;
  shash_pkg::word_t       h_r [8];
  shash_pkg::word_t       v_r [8];
  shash_pkg::word_t       w_r [16];

  // Block buffer memory, undefined until written
  shash_pkg::word_t       buf_mem [16];
  shash_pkg::word_t       rd_data_r;
  logic [3:0]             rd_addr;
  logic                   mem_we;

  logic                   in_acc;
  logic                   out_acc;

  logic [6:0]             cut;
  logic                   mark;
  logic                   len_sel;
  logic [63:0]            bit_len;
  shash_pkg::word_t       pad_word;
  shash_pkg::word_t       w_new;
  shash_pkg::word_t       t1;
  shash_pkg::word_t       t2;

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;
  assign mem_we  = in_acc && (in_ch.command == shash_pkg::CMD_APPEND);
  assign bit_len = {len_r, 3'b000};

  // Next state and handshake outputs
  always_comb begin
    state_nxt    = state_r;
    kind_nxt     = kind_r;
    in_ch.ready  = 1'b0;
    out_ch.valid = 1'b0;
    case (state_r)
      shash_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          if (in_ch.command == shash_pkg::CMD_FINISH) begin
            kind_nxt  = (fill_r >= shash_pkg::LEN_FIELD_BYTE) ? shash_pkg::BLK_PAD
                                                              : shash_pkg::BLK_PAD_LEN;
            state_nxt = shash_pkg::ST_PREP;
          end else if (fill_r == shash_pkg::LAST_BYTE) begin
            kind_nxt  = shash_pkg::BLK_FULL;
            state_nxt = shash_pkg::ST_PREP;
          end
        end
      end
      shash_pkg::ST_PREP: begin
        state_nxt = shash_pkg::ST_ROUND;
      end
      shash_pkg::ST_ROUND: begin
        if (rnd_r == shash_pkg::LAST_ROUND) begin
          state_nxt = shash_pkg::ST_UPDATE;
        end
      end
      shash_pkg::ST_UPDATE: begin
        case (kind_r)
          shash_pkg::BLK_FULL: state_nxt = shash_pkg::ST_IDLE;
          shash_pkg::BLK_PAD: begin
            kind_nxt  = shash_pkg::BLK_LEN;
            state_nxt = shash_pkg::ST_PREP;
          end
          default: state_nxt = shash_pkg::ST_OUT;
        endcase
      end
      shash_pkg::ST_OUT: begin
        out_ch.valid = 1'b1;
        if (out_ch.ready && (idx_r == shash_pkg::LAST_DIGEST)) begin
          state_nxt = shash_pkg::ST_IDLE;
        end
      end
      default: state_nxt = shash_pkg::ST_IDLE;
    endcase
  end

  // Drive the digest word from the hash registers
  assign out_ch.digest_word = h_r[idx_r];
  assign out_ch.word_index  = idx_r;
  assign out_ch.last_word   = (idx_r == shash_pkg::LAST_DIGEST);

  // Control state, counters and hash words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= shash_pkg::ST_IDLE;
      kind_r  <= shash_pkg::BLK_FULL;
      rnd_r   <= '0;
      idx_r   <= '0;
      fill_r  <= '0;
      len_r   <= '0;
      h_r     <= shash_pkg::INIT_HASH;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
      case (state_r)
        shash_pkg::ST_IDLE: begin
          if (mem_we) begin
            fill_r <= fill_r + 6'd1;
            len_r  <= len_r + 61'd1;
          end
        end
        shash_pkg::ST_PREP: begin
          rnd_r <= '0;
        end
        shash_pkg::ST_ROUND: begin
          rnd_r <= rnd_r + 6'd1;
        end
        shash_pkg::ST_UPDATE: begin
          for (int i = 0; i < 8; i++) begin
            h_r[i] <= h_r[i] + v_r[i];
          end
        end
        shash_pkg::ST_OUT: begin
          if (out_ch.ready) begin
            idx_r <= idx_r + 3'd1;
            // Return to the initial state after the last word
            if (idx_r == shash_pkg::LAST_DIGEST) begin
              h_r    <= shash_pkg::INIT_HASH;
              fill_r <= '0;
              len_r  <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Buffer read address: word 0 while priming, then one ahead of the round
  assign rd_addr = (state_r == shash_pkg::ST_PREP) ? 4'd0 : (rnd_r[3:0] + 4'd1);

  // Block buffer: byte-lane write on append, registered word read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      buf_mem[fill_r[5:2]][{~fill_r[1:0], 3'b000} +: 8] <= in_ch.data_byte;
    end
    rd_data_r <= buf_mem[rd_addr];
  end

  // Padding limits of the current block
  always_comb begin
    case (kind_r)
      shash_pkg::BLK_FULL: cut = shash_pkg::BLOCK_BYTES;
      shash_pkg::BLK_LEN:  cut = 7'd0;
      default:             cut = {1'b0, fill_r};
    endcase
    mark    = (kind_r == shash_pkg::BLK_PAD) || (kind_r == shash_pkg::BLK_PAD_LEN);
    len_sel = (kind_r == shash_pkg::BLK_PAD_LEN) || (kind_r == shash_pkg::BLK_LEN);
  end

  // Build the schedule word: buffer bytes, pad mark, zero fill, bit length
  always_comb begin
    logic [6:0] b;
    b = '0;
    for (int k = 0; k < 4; k++) begin
      b = {1'b0, rnd_r[3:0], 2'(k)};
      if (b < cut) begin
        pad_word[31 - 8*k -: 8] = rd_data_r[31 - 8*k -: 8];
      end else if ((b == cut) && mark) begin
        pad_word[31 - 8*k -: 8] = shash_pkg::PAD_MARK;
      end else begin
        pad_word[31 - 8*k -: 8] = 8'h00;
      end
    end
    if (len_sel && (rnd_r[3:0] == shash_pkg::LEN_HI_WORD)) begin
      pad_word = bit_len[63:32];
    end else if (len_sel && (rnd_r[3:0] == shash_pkg::LEN_LO_WORD)) begin
      pad_word = bit_len[31:0];
    end
  end

  // Message schedule and round function
  always_comb begin
    if (rnd_r < 6'd16) begin
      w_new = pad_word;
    end else begin
      w_new = shash_pkg::small_sigma1(w_r[14]) + w_r[9] +
              shash_pkg::small_sigma0(w_r[1]) + w_r[0];
    end
    t1 = v_r[7] + shash_pkg::big_sigma1(v_r[4]) +
         shash_pkg::choose(v_r[4], v_r[5], v_r[6]) + shash_pkg::ROUND_K[rnd_r] + w_new;
    t2 = shash_pkg::big_sigma0(v_r[0]) + shash_pkg::majority(v_r[0], v_r[1], v_r[2]);
  end

  // Working variables and schedule window
  always_ff @(posedge clk) begin
    if (state_r == shash_pkg::ST_PREP) begin
      v_r <= h_r;
    end else if (state_r == shash_pkg::ST_ROUND) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= w_r[i + 1];
      end
      w_r[15] <= w_new;
    end
  end

  // Input and digest sides never open together
  assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("input taken while digest words pending");

  // Digest words follow one another in index order
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && !out_ch.last_word) |=>
      (out_ch.valid && (out_ch.word_index == $past(out_ch.word_index) + 3'd1)))
    else $error("digest word sequence broken");

  // After the last word the block is ready for a new message
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_ch.last_word) |=> (in_ch.ready && (fill_r == 6'd0)))
    else $error("block not back to initial state after digest");

endmodule

[tb/sv/sha256_stream_hasher_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_stream_hasher_test
// Self-checking bench for the SHA-256 stream hasher. Byte and finish items
// are queued up front and fed by a valid/ready driver. A software SHA-256
// runs as each item is taken and queues the eight digest words that a finish
// must produce. A monitor compares each outgoing word against that queue.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_test;

  localparam int CYCLE_LIMIT      = 200000;
  localparam int TAIL_CYCLES      = 200;
  localparam int RANDOM_ITEMS     = 170;
  localparam int IDLE_PERCENT     = 19;
  localparam int CALM_FROM        = 500;
  localparam int CALM_TO          = 1100;
  localparam int HOLD_CYCLES      = 250;
  localparam int HOLD_AFTER_WORDS = 16;

  localparam logic [31:0] HASH_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_CONST [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } cmd_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_item_t;

  logic clk;
  logic rst_n;

  shash_in_if  cmd_if ();
  shash_out_if digest_if ();

  sha256_stream_hasher u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (cmd_if),
    .out_ch (digest_if)
  );

  // Items waiting to be offered, digest words waiting to come out
  cmd_item_t    cmd_backlog [$];
  digest_item_t digest_due [$];

  // Software hash state
  logic [31:0] chain_words [8];
  logic [7:0]  block_bytes [64];
  int unsigned block_fill;
  logic [60:0] msg_len_bytes;

  int cycle_count   = 0;
  int failures      = 0;
  int words_checked = 0;
  int hold_left     = 0;
  bit cmd_taken     = 1'b0;
  bit pressure_done = 1'b0;

  function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void hash_restart();
    chain_words   = HASH_IV;
    block_fill    = 0;
    msg_len_bytes = '0;
  endfunction

  // Append one item to the tail of the pending stimulus
  function automatic void enqueue_cmd(input cmd_item_t item);
    cmd_backlog = {cmd_backlog, item};
  endfunction

  // Append one expected digest word to the tail of the check queue
  function automatic void enqueue_digest(input digest_item_t item);
    digest_due = {digest_due, item};
  endfunction

  // Run 64 rounds over the block buffer and fold the result into the chain
  function automatic void compress_block();
    logic [31:0] sched [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2;
    for (int i = 0; i < 16; i++)
      sched[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2],
                  block_bytes[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = ror32(sched[i-15], 7) ^ ror32(sched[i-15], 18) ^ (sched[i-15] >> 3);
      s1 = ror32(sched[i-2], 17) ^ ror32(sched[i-2], 19) ^ (sched[i-2] >> 10);
      sched[i] = sched[i-16] + s0 + sched[i-7] + s1;
    end
    v = chain_words;
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[i] + sched[i];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++)
      chain_words[i] = chain_words[i] + v[i];
  endfunction

  // Absorb one taken item; a finish pads, compresses and queues the digest
  function automatic void sha256_absorb(input cmd_item_t item);
    logic [63:0] bit_len;
    int unsigned pos;
    if (item.command == shash_pkg::CMD_APPEND) begin
      block_bytes[block_fill] = item.data_byte;
      block_fill++;
      msg_len_bytes++;
      if (block_fill == 64) begin
        compress_block();
        block_fill = 0;
      end
    end else begin
      bit_len = {msg_len_bytes, 3'b000};
      block_bytes[block_fill] = 8'h80;
      pos = block_fill + 1;
      // no room left for the length: close this block, length goes in the next
      if (pos > 56) begin
        for (int j = pos; j < 64; j++)
          block_bytes[j] = 8'h00;
        compress_block();
        pos = 0;
      end
      for (int j = pos; j < 56; j++)
        block_bytes[j] = 8'h00;
      for (int j = 0; j < 8; j++)
        block_bytes[56+j] = bit_len[63-8*j -: 8];
      compress_block();
      for (int j = 0; j < 8; j++)
        enqueue_digest('{digest_word: chain_words[j], word_index: 3'(j),
                         last_word: (j == 7)});
      hash_restart();
    end
  endfunction

  function automatic void queue_byte(input logic [7:0] value);
    enqueue_cmd('{command: shash_pkg::CMD_APPEND, data_byte: value});
  endfunction

  // Payload byte of a finish is don't-care; keep it random
  function automatic void queue_finish();
    enqueue_cmd('{command: shash_pkg::CMD_FINISH, data_byte: 8'($urandom)});
  endfunction

  function automatic void queue_message(input int unsigned len);
    for (int i = 0; i < len; i++)
      queue_byte(8'($urandom));
    queue_finish();
  endfunction

  // Random idle decision, switched off inside the calm window
  function automatic bit idle_now();
    return (cycle_count < CALM_FROM || cycle_count >= CALM_TO) &&
           ($urandom_range(99) < IDLE_PERCENT);
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Cycle count and timeout
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Driver: hold the offered item until taken, then advance or idle
  always @(negedge clk) begin
    cmd_item_t next_item;
    if (rst_n && (!cmd_if.valid || cmd_taken)) begin
      if (cmd_backlog.size() != 0 && !idle_now()) begin
        next_item = cmd_backlog.pop_front();
        cmd_if.valid     <= 1'b1;
        cmd_if.command   <= next_item.command;
        cmd_if.data_byte <= next_item.data_byte;
      end else begin
        cmd_if.valid <= 1'b0;
      end
    end
    cmd_taken = 1'b0;
  end

  // Receiver: random stalls, plus one long hold-off to back up the input
  always @(negedge clk) begin
    if (hold_left > 0) begin
      digest_if.ready <= 1'b0;
      hold_left--;
    end else begin
      digest_if.ready <= rst_n && !idle_now();
    end
  end

  // Sample both channels: predict on taken items, check outgoing words
  always @(posedge clk) begin
    digest_item_t want;
    if (rst_n && cmd_if.valid && cmd_if.ready) begin
      sha256_absorb('{command: cmd_if.command, data_byte: cmd_if.data_byte});
      cmd_taken = 1'b1;
    end
    if (rst_n && digest_if.valid && digest_if.ready) begin
      if (digest_due.size() == 0) begin
        $display("%0t: digest word %h index %0d last %b arrived with none expected",
                 $time, digest_if.digest_word, digest_if.word_index, digest_if.last_word);
        failures++;
      end else begin
        want = digest_due.pop_front();
        if (digest_if.digest_word !== want.digest_word) begin
          $display("%0t: digest_word mismatch: expected %h, actual %h", $time,
                   want.digest_word, digest_if.digest_word);
          failures++;
        end
        if (digest_if.word_index !== want.word_index) begin
          $display("%0t: word_index mismatch: expected %0d, actual %0d", $time,
                   want.word_index, digest_if.word_index);
          failures++;
        end
        if (digest_if.last_word !== want.last_word) begin
          $display("%0t: last_word mismatch: expected %b, actual %b", $time,
                   want.last_word, digest_if.last_word);
          failures++;
        end
      end
      words_checked++;
      if (words_checked == HOLD_AFTER_WORDS && !pressure_done) begin
        hold_left     = HOLD_CYCLES;
        pressure_done = 1'b1;
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int unsigned len;
    int unsigned random_items;
    rst_n            = 1'b0;
    cmd_if.valid     = 1'b0;
    cmd_if.command   = shash_pkg::CMD_APPEND;
    cmd_if.data_byte = 8'h00;
    digest_if.ready  = 1'b0;
    hash_restart();

    // Directed: empty message, "abc", extreme bytes, back-to-back finishes
    queue_finish();
    queue_byte(8'h61);
    queue_byte(8'h62);
    queue_byte(8'h63);
    queue_finish();
    queue_byte(8'h00);
    queue_finish();
    queue_byte(8'hff);
    queue_finish();
    queue_finish();
    queue_byte(8'hff);
    queue_byte(8'h00);
    queue_byte(8'hff);
    queue_finish();

    // Random: padding spills into an extra block, then a full block first,
    // then a mix of short messages and ones just under the spill boundary
    len = $urandom_range(63, 56);
    queue_message(len);
    random_items = len + 1;
    len = $urandom_range(72, 64);
    queue_message(len);
    random_items += len + 1;
    while (random_items < RANDOM_ITEMS) begin
      len = $urandom_range(1) ? $urandom_range(8) : $urandom_range(55, 40);
      // trim the last message so the item count lands on the target
      if (random_items + len + 1 > RANDOM_ITEMS)
        len = RANDOM_ITEMS - random_items - 1;
      queue_message(len);
      random_items += len + 1;
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Drain: all items taken and every digest word seen
    while (cmd_backlog.size() != 0 || cmd_if.valid || digest_due.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
